// ----- src/stca_pkg.sv -----
// ----------------------------------------------------------------------------
// stca_pkg: shared types and constants
// Column layout, window struct and the popcount helper used by the
// space-time totalistic automaton step.
// ----------------------------------------------------------------------------
package stca_pkg;

  // One cell history: bit 0 newest, bit 2 oldest generation.
  localparam int unsigned HIST_W = 3;
  // One column: above in bits 0..2, center in 3..5, below in 6..8.
  localparam int unsigned COL_W  = 3 * HIST_W;
  // Popcount of one column, 0..9.
  localparam int unsigned CNT_W  = 4;
  // Window sum, 0..27.
  localparam int unsigned SUM_W  = 5;
  // Result history: new bit plus the three old generations.
  localparam int unsigned NHIST_W = HIST_W + 1;

  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;

  // Register indexes of the configuration map.
  localparam logic REG_RULE_WORD = 1'b0;

  localparam logic [APB_DW-1:0] RULE_RESET = 32'd33564695;

  typedef logic [COL_W-1:0] col_t;

  // Window snapshot handed from the column stage to the evaluation stage.
  typedef struct packed {
    col_t left;
    col_t mid;
    col_t right;
    logic emit_mid;  // mid holds a column that still owes a result
    logic last;      // right is the final column of the row
  } win_t;

  // Number of set bits in one column.
  function automatic logic [CNT_W-1:0] col_count(input col_t c);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < COL_W; i++) begin
      n = n + CNT_W'(c[i]);
    end
    return n;
  endfunction

endpackage

// ----- src/stca_window.sv -----
// ----------------------------------------------------------------------------
// stca_window: column window stage
// Keeps the two previous columns of the row and registers the 3x3 window
// of each accepted column for the evaluation stage.
// ----------------------------------------------------------------------------
module stca_window (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [stca_pkg::HIST_W-1:0] in_above_hist,
  input  logic [stca_pkg::HIST_W-1:0] in_center_hist,
  input  logic [stca_pkg::HIST_W-1:0] in_below_hist,
  input  logic                   in_row_end,
  output logic                   win_valid,
  output stca_pkg::win_t         win,
  input  logic                   win_take
);
  import stca_pkg::*;

  col_t left_col_r, left_col_nxt;
  col_t mid_col_r, mid_col_nxt;
  logic have_mid_r, have_mid_nxt;
  logic win_valid_r, win_valid_nxt;
  win_t win_r, win_nxt;
  col_t in_col;
  logic in_beat;

  assign in_col   = {in_below_hist, in_center_hist, in_above_hist};
  assign in_ready = !win_valid_r || win_take;
  assign in_beat  = in_valid && in_ready;

  // Row state: shift the window on each beat, clear it after the row end.
  always_comb begin
    left_col_nxt  = left_col_r;
    mid_col_nxt   = mid_col_r;
    have_mid_nxt  = have_mid_r;
    win_valid_nxt = win_valid_r && !win_take;
    win_nxt       = win_r;
    if (in_beat) begin
      win_valid_nxt     = 1'b1;
      win_nxt.left      = left_col_r;
      win_nxt.mid       = mid_col_r;
      win_nxt.right     = in_col;
      win_nxt.emit_mid  = have_mid_r;
      win_nxt.last      = in_row_end;
      if (in_row_end) begin
        left_col_nxt = '0;
        mid_col_nxt  = '0;
        have_mid_nxt = 1'b0;
      end else begin
        left_col_nxt = mid_col_r;
        mid_col_nxt  = in_col;
        have_mid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_col_r  <= '0;
      mid_col_r   <= '0;
      have_mid_r  <= 1'b0;
      win_valid_r <= 1'b0;
    end else begin
      left_col_r  <= left_col_nxt;
      mid_col_r   <= mid_col_nxt;
      have_mid_r  <= have_mid_nxt;
      win_valid_r <= win_valid_nxt;
    end
  end

  // Window payload needs no reset.
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  assign win_valid = win_valid_r;
  assign win       = win_r;

endmodule

// ----- src/stca_eval.sv -----
// ----------------------------------------------------------------------------
// stca_eval: rule evaluation and result register
// Counts the window bits, looks up the rule word and holds up to two
// results per column, which are sent out one beat at a time.
// ----------------------------------------------------------------------------
module stca_eval (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [stca_pkg::APB_DW-1:0] rule_word,
  input  logic                    win_valid,
  input  stca_pkg::win_t          win,
  output logic                    win_take,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [stca_pkg::NHIST_W-1:0] out_next_hist,
  output logic                    out_last_in_row
);
  import stca_pkg::*;

  logic [CNT_W-1:0] cnt_left, cnt_mid, cnt_right;
  logic [SUM_W-1:0] sum_a, sum_b;
  logic [NHIST_W-1:0] hist_a, hist_b;
  logic va_r, va_nxt, vb_r, vb_nxt;
  logic [NHIST_W-1:0] ha_r, ha_nxt, hb_r, hb_nxt;
  logic out_beat, drains;

  // Column counts; the row-end result sees an empty right neighbor.
  assign cnt_left  = col_count(win.left);
  assign cnt_mid   = col_count(win.mid);
  assign cnt_right = col_count(win.right);
  assign sum_a = SUM_W'(cnt_left) + SUM_W'(cnt_mid) + SUM_W'(cnt_right);
  assign sum_b = SUM_W'(cnt_mid) + SUM_W'(cnt_right);

  // New history: center's old bits shifted up, rule bit at the bottom.
  assign hist_a = {win.mid[2*HIST_W-1:HIST_W], rule_word[sum_a]};
  assign hist_b = {win.right[2*HIST_W-1:HIST_W], rule_word[sum_b]};

  // The result register is free next cycle if it is empty or its only
  // remaining result leaves now.
  assign out_beat = out_valid && out_ready;
  assign drains   = (!va_r && !vb_r) || (out_ready && (va_r ^ vb_r));
  assign win_take = win_valid && drains;

  always_comb begin
    va_nxt = va_r;
    vb_nxt = vb_r;
    ha_nxt = ha_r;
    hb_nxt = hb_r;
    if (out_beat) begin
      if (va_r) begin
        va_nxt = 1'b0;
      end else begin
        vb_nxt = 1'b0;
      end
    end
    if (win_take) begin
      va_nxt = win.emit_mid;
      vb_nxt = win.last;
      ha_nxt = hist_a;
      hb_nxt = hist_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ha_r <= ha_nxt;
    hb_r <= hb_nxt;
  end

  // The interior result goes first, the row-end result second.
  assign out_valid       = va_r || vb_r;
  assign out_next_hist   = va_r ? ha_r : hb_r;
  assign out_last_in_row = !va_r;

endmodule

// ----- src/spacetime_totalistic_automaton_step.sv -----
// Path: the beat that completes a column's window (the next column, or the same
// beat for a row's last column) loads the window register, then its results load
// the result register. Throughput while out_ready is high: one column per cycle,
// and the result register drains one beat a cycle; a row of two or more columns
// ends with two results, and the next window waits for the first to leave. A
// one-column row holds a single result. Reset (synchronous, rst_n low): window
// and result register empty, rule word set to its default; no clearing pass.
// ----------------------------------------------------------------------------
// spacetime_totalistic_automaton_step: top level
// One generation of a 3x3, three-generation totalistic automaton streamed
// column by column, with an APB register for the rule word.
// ----------------------------------------------------------------------------
module spacetime_totalistic_automaton_step (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [stca_pkg::APB_AW-1:0]  paddr,
  input  logic [stca_pkg::APB_DW-1:0]  pwdata,
  output logic [stca_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [stca_pkg::HIST_W-1:0]  in_above_hist,
  input  logic [stca_pkg::HIST_W-1:0]  in_center_hist,
  input  logic [stca_pkg::HIST_W-1:0]  in_below_hist,
  input  logic                         in_row_end,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [stca_pkg::NHIST_W-1:0] out_next_hist,
  output logic                         out_last_in_row
);
  import stca_pkg::*;

  logic [APB_DW-1:0] rule_word_r, rule_word_nxt;
  logic reg_idx;
  logic win_valid, win_take;
  win_t win;

  // Configuration register; word index taken from the byte address.
  assign reg_idx = paddr[APB_AW-1:2];
  assign pready  = 1'b1;

  always_comb begin
    rule_word_nxt = rule_word_r;
    if (psel && penable && pwrite && pready && (reg_idx == REG_RULE_WORD)) begin
      rule_word_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_word_r <= RULE_RESET;
    end else begin
      rule_word_r <= rule_word_nxt;
    end
  end

  // Read back; addresses past the map read as zero.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_RULE_WORD: prdata = rule_word_r;
      default:       prdata = '0;
    endcase
  end

  stca_window u_window (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_above_hist  (in_above_hist),
    .in_center_hist (in_center_hist),
    .in_below_hist  (in_below_hist),
    .in_row_end     (in_row_end),
    .win_valid      (win_valid),
    .win            (win),
    .win_take       (win_take)
  );

  stca_eval u_eval (
    .clk             (clk),
    .rst_n           (rst_n),
    .rule_word       (rule_word_r),
    .win_valid       (win_valid),
    .win             (win),
    .win_take        (win_take),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_next_hist   (out_next_hist),
    .out_last_in_row (out_last_in_row)
  );

endmodule

// ----- src/stca_checker.sv -----
// ----------------------------------------------------------------------------
// stca_checker: port-level checks
// Watches the top-level ports for reset, stall and ready behavior.
// ----------------------------------------------------------------------------
module stca_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         pready,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [stca_pkg::NHIST_W-1:0] out_next_hist,
  input logic                         out_last_in_row
);
  import stca_pkg::*;

  // Nothing is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present right after reset");

  // With the result side empty, both pipeline stages can move, so input is open.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while no result is pending");

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_next_hist) && $stable(out_last_in_row))
    else $error("stalled result beat changed or dropped");

  // The register port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind spacetime_totalistic_automaton_step stca_checker u_stca_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .pready          (pready),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_next_hist   (out_next_hist),
  .out_last_in_row (out_last_in_row)
);

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for spacetime_totalistic_automaton_step
// Streams rows of cell columns into the block and writes the rule word over
// the register port. A local model of the 3x3, three-generation window
// predicts every new cell history. A monitor compares each result beat with
// the oldest prediction. Both sides of the stream stall at random.
// ----------------------------------------------------------------------------
module tb;
  import stca_pkg::*;

  typedef struct packed {
    logic [NHIST_W-1:0] next_hist;
    logic               last;
  } cell_result_t;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  // Register port.
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Column stream and result stream.
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [HIST_W-1:0] in_above_hist = '0;
  logic [HIST_W-1:0] in_center_hist = '0;
  logic [HIST_W-1:0] in_below_hist = '0;
  logic              in_row_end = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [NHIST_W-1:0] out_next_hist;
  logic               out_last_in_row;

  // Local copy of the block's state and rule word.
  logic [APB_DW-1:0] model_rule = RULE_RESET;
  col_t              model_left = '0;
  col_t              model_mid = '0;
  logic [1:0]        model_held = '0;

  cell_result_t pending_cells[$];
  int           errors = 0;
  bit           no_idle = 1'b0;

  spacetime_totalistic_automaton_step DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_above_hist   (in_above_hist),
    .in_center_hist  (in_center_hist),
    .in_below_hist   (in_below_hist),
    .in_row_end      (in_row_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_next_hist   (out_next_hist),
    .out_last_in_row (out_last_in_row)
  );

  // New history of the center cell of mid: sum all 27 bits, pick the rule bit.
  function automatic logic [NHIST_W-1:0] evolve_cell(input col_t left, input col_t mid,
                                                     input col_t right);
    logic [SUM_W-1:0] total;
    total = SUM_W'($countones(left)) + SUM_W'($countones(mid)) + SUM_W'($countones(right));
    return {mid[2*HIST_W-1:HIST_W], model_rule[total]};
  endfunction

  // Advance the window model by one accepted column and queue its results.
  task automatic predict_column(input logic [HIST_W-1:0] above, input logic [HIST_W-1:0] center,
                                input logic [HIST_W-1:0] below, input logic last);
    col_t col;
    col = {below, center, above};
    if (model_held != 2'd0) begin
      pending_cells.push_back('{next_hist: evolve_cell(model_left, model_mid, col), last: 1'b0});
    end
    model_left = model_mid;
    model_mid = col;
    if (model_held < 2'd2) begin
      model_held = model_held + 2'd1;
    end
    // The final column sees zeros on its right, and the row state clears.
    if (last) begin
      pending_cells.push_back('{next_hist: evolve_cell(model_left, model_mid, '0), last: 1'b1});
      model_left = '0;
      model_mid = '0;
      model_held = '0;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Send one column beat; valid stays high afterwards unless the next call idles or a drain stops the stream.
  task automatic send_column(input logic [HIST_W-1:0] above, input logic [HIST_W-1:0] center,
                             input logic [HIST_W-1:0] below, input logic last);
    if (!no_idle && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_above_hist <= above;
    in_center_hist <= center;
    in_below_hist <= below;
    in_row_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_column(above, center, below, last);
  endtask

  // Stop sending and wait until every predicted result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    // A held column may still sit in the pipeline without owing a result yet.
    repeat (6) @(posedge clk);
  endtask

  // APB write of the rule word: setup cycle, then access cycle.
  task automatic write_rule(input logic [APB_DW-1:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {REG_RULE_WORD, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    model_rule = value;
  endtask

  function automatic logic [HIST_W-1:0] pick_hist(input int density);
    logic [HIST_W-1:0] h;
    for (int i = 0; i < HIST_W; i++) begin
      h[i] = ($urandom_range(7) < density);
    end
    return h;
  endfunction

  // One row of random columns; density 0..8 sets the chance, in eighths, that each bit is live.
  task automatic send_row(input int len, input int density);
    for (int i = 0; i < len; i++) begin
      send_column(pick_hist(density), pick_hist(density), pick_hist(density), i == len - 1);
    end
  endtask

  // Row edges, single-column rows and all-ones columns under the default rule.
  task automatic test_window_edges();
    send_column(3'd0, 3'd0, 3'd0, 1'b1);
    send_column(3'd7, 3'd7, 3'd7, 1'b1);
    send_column(3'd7, 3'd7, 3'd7, 1'b0);
    send_column(3'd7, 3'd7, 3'd7, 1'b1);
    send_column(3'd1, 3'd2, 3'd4, 1'b0);
    send_column(3'd7, 3'd7, 3'd7, 1'b0);
    send_column(3'd7, 3'd7, 3'd7, 1'b0);
    send_column(3'd4, 3'd2, 3'd1, 1'b1);
    drain_results();
  endtask

  // Extreme rule words, with windows that reach counts 0 and 27.
  task automatic test_rule_extremes();
    write_rule(32'hFFFF_FFFF);
    send_column(3'd0, 3'd5, 3'd0, 1'b0);
    send_column(3'd0, 3'd0, 3'd0, 1'b1);
    drain_results();
    write_rule(32'h0000_0000);
    send_column(3'd7, 3'd7, 3'd7, 1'b0);
    send_column(3'd7, 3'd7, 3'd7, 1'b1);
    drain_results();
    write_rule(32'h0800_0000);
    send_column(3'd7, 3'd7, 3'd7, 1'b0);
    send_column(3'd7, 3'd7, 3'd7, 1'b0);
    send_column(3'd7, 3'd7, 3'd7, 1'b0);
    send_column(3'd7, 3'd7, 3'd7, 1'b1);
    drain_results();
    write_rule(32'h0000_0001);
    send_column(3'd0, 3'd0, 3'd0, 1'b0);
    send_column(3'd0, 3'd0, 3'd0, 1'b0);
    send_column(3'd0, 3'd0, 3'd0, 1'b1);
    drain_results();
  endtask

  // Short rows of every length from one to six columns, then a mid-row pause.
  task automatic test_row_lengths();
    write_rule($urandom);
    for (int len = 1; len <= 6; len++) begin
      send_row(len, $urandom_range(8));
    end
    send_column(pick_hist(4), pick_hist(4), pick_hist(4), 1'b0);
    send_column(pick_hist(4), pick_hist(4), pick_hist(4), 1'b0);
    // Sender holds off here until every owed result has come out.
    drain_results();
    send_column(pick_hist(4), pick_hist(4), pick_hist(4), 1'b1);
    drain_results();
  endtask

  // Random rows under a series of rule words, one burst without any stalls.
  task automatic test_random_rows();
    logic [APB_DW-1:0] rules[6];
    int                sent;
    int                len;
    rules[0] = $urandom;
    rules[1] = 32'hFFFF_FFFF;
    rules[2] = $urandom;
    rules[3] = 32'h0000_0000;
    rules[4] = $urandom;
    rules[5] = RULE_RESET;
    for (int p = 0; p < 6; p++) begin
      write_rule(rules[p]);
      no_idle = (p == 2);
      sent = 0;
      while (sent < 300) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 8);
        send_row(len, $urandom_range(8));
        sent += len;
        if ($urandom_range(29) == 0) begin
          drain_results();
        end
      end
      drain_results();
      no_idle = 1'b0;
    end
  endtask

  // Result side: random back-pressure, none during the calm burst.
  always @(posedge clk) begin
    out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 7);
  end

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    cell_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_cells.size() == 0) begin
        report_mismatch($sformatf("unexpected result next_hist=%0h", out_next_hist));
      end else begin
        want = pending_cells.pop_front();
        if (out_next_hist !== want.next_hist) begin
          report_mismatch($sformatf("next_hist %0h, expected %0h", out_next_hist,
                                    want.next_hist));
        end
        if (out_last_in_row !== want.last) begin
          report_mismatch($sformatf("last_in_row %0b, expected %0b", out_last_in_row,
                                    want.last));
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_window_edges();
    test_rule_extremes();
    test_row_lengths();
    test_random_rows();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog for a hung stream.
  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
src/stca_pkg.sv
src/stca_window.sv
src/stca_eval.sv
src/spacetime_totalistic_automaton_step.sv
src/stca_checker.sv
test/tb.sv
